/* sv/xte_pkg.sv */
package xte_pkg;

   // Character codes used by the escaper
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_QUOT = 8'h22;
   localparam logic [7:0] CH_APOS = 8'h27;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_X    = 8'h78;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CTRL_LIMIT = 8'd32;

   // Entity text, left aligned in six byte slots
   localparam logic [47:0] ENT_AMP  = {"&amp;", 8'h00};
   localparam logic [47:0] ENT_LT   = {"&lt;", 16'h0000};
   localparam logic [47:0] ENT_GT   = {"&gt;", 16'h0000};
   localparam logic [47:0] ENT_QUOT = "&quot;";
   localparam logic [47:0] ENT_APOS = "&apos;";

   localparam int unsigned TOK_MAX = 3;

   // Tokens released by one input item: a byte plus whether it is escaped
   typedef struct packed {
      logic [1:0]         count;
      logic [2:0][7:0]    tok_byte;
      logic [2:0]         tok_esc;
      logic               last;
   } xte_plan_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = 8'h30 + {4'h0, d};
      end else begin
         r = 8'h37 + {4'h0, d};
      end
      return r;
   endfunction

   // Full expansion of a token, first byte in the top slot
   function automatic logic [47:0] exp_word(input logic [7:0] b, input logic esc);
      logic [47:0] w;
      w = {b, 40'h0};
      if (esc) begin
         case (b)
            CH_AMP:  w = ENT_AMP;
            CH_LT:   w = ENT_LT;
            CH_GT:   w = ENT_GT;
            CH_QUOT: w = ENT_QUOT;
            CH_APOS: w = ENT_APOS;
            default: begin
               if (b < CTRL_LIMIT) begin
                  w = {"&#x", hex_digit(b[7:4]), hex_digit(b[3:0]), ";"};
               end
            end
         endcase
      end
      return w;
   endfunction

   // Number of bytes in a token's expansion, 1 to 6
   function automatic logic [2:0] exp_len(input logic [7:0] b, input logic esc);
      logic [2:0] n;
      n = 3'd1;
      if (esc) begin
         case (b)
            CH_AMP:  n = 3'd5;
            CH_LT:   n = 3'd4;
            CH_GT:   n = 3'd4;
            CH_QUOT: n = 3'd6;
            CH_APOS: n = 3'd6;
            default: begin
               if (b < CTRL_LIMIT) begin
                  n = 3'd6;
               end
            end
         endcase
      end
      return n;
   endfunction

endpackage

/* sv/xte_req_if.sv */
interface xte_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* sv/xte_rsp_if.sv */
interface xte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_run_end;
   logic       out_string_end;

   modport source (output valid, output out_byte, output out_run_end,
                   output out_string_end, input ready);
   modport sink   (input valid, input out_byte, input out_run_end,
                   input out_string_end, output ready);
endinterface

/* sv/xte_planner.sv */
module xte_planner (
   input  logic                 clock,
   input  logic                 reset,
   xte_req_if.sink              req_chan,
   input  logic                 can_load,
   output logic                 plan_take,
   output xte_pkg::xte_plan_type plan
);
   import xte_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic [7:0] held_ff [2];
   logic [7:0] held_in [2];
   logic [1:0] held_cnt_ff;
   logic [1:0] held_cnt_in;
   logic       raw_ff;
   logic       raw_in;

   assign plan_take    = in_valid_ff && can_load;
   assign req_chan.ready = !in_valid_ff || plan_take;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.in_byte;
         in_last_ff <= req_chan.in_last;
      end
   end

   // Walk the held bytes plus the new one, at most three positions
   always_comb begin
      logic [7:0] q [5];
      logic [2:0] n;
      logic [1:0] cnt;
      logic       raw;
      logic       stop;
      logic [1:0] ntok;
      logic [7:0] b;

      cnt = (held_cnt_ff == 2'd3) ? 2'd2 : held_cnt_ff;
      b   = 8'h00;
      for (int i = 0; i < 5; i++) begin
         q[i] = 8'h00;
      end
      case (cnt)
         2'd0: begin
            q[0] = in_byte_ff;
         end
         2'd1: begin
            q[0] = held_ff[0];
            q[1] = in_byte_ff;
         end
         default: begin
            q[0] = held_ff[0];
            q[1] = held_ff[1];
            q[2] = in_byte_ff;
         end
      endcase
      n = {1'b0, cnt} + 3'd1;

      raw  = raw_ff;
      stop = 1'b0;
      ntok = 2'd0;
      plan.tok_byte = '0;
      plan.tok_esc  = '0;
      for (int h = 0; h < TOK_MAX; h++) begin
         if (!stop && (3'(h) < n)) begin
            b = q[h];
            plan.tok_byte[h] = b;
            if (raw) begin
               if (b == CH_SEMI || (in_last_ff && (3'(h + 1) == n))) begin
                  raw = 1'b0;
                  plan.tok_esc[h] = 1'b1;
               end
            end else if (b == CH_AMP) begin
               if ((3'(h + 2) <= n) && (q[h + 1] != CH_HASH)) begin
                  plan.tok_esc[h] = 1'b1;
               end else if (3'(h + 3) <= n) begin
                  if (q[h + 2] == CH_X) begin
                     raw = 1'b1;
                  end else begin
                     plan.tok_esc[h] = 1'b1;
                  end
               end else if (in_last_ff) begin
                  plan.tok_esc[h] = 1'b1;
               end else begin
                  stop = 1'b1;
               end
            end else begin
               plan.tok_esc[h] = 1'b1;
            end
            if (!stop) begin
               ntok = 2'(h + 1);
            end
         end
      end

      plan.count  = ntok;
      plan.last   = in_last_ff;
      raw_in      = raw;
      held_cnt_in = 2'(n - {1'b0, ntok});
      held_in[0]  = q[ntok];
      held_in[1]  = q[3'(ntok) + 3'd1];
   end

   // Lookahead state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= 2'd0;
         raw_ff      <= 1'b0;
      end else if (plan_take) begin
         held_cnt_ff <= held_cnt_in;
         raw_ff      <= raw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (plan_take) begin
         held_ff[0] <= held_in[0];
         held_ff[1] <= held_in[1];
      end
   end

endmodule

/* sv/xte_emitter.sv */
module xte_emitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 plan_take,
   input  xte_pkg::xte_plan_type plan,
   output logic                 can_load,
   xte_rsp_if.source            rsp_chan
);
   import xte_pkg::*;

   logic             busy_ff;
   logic [2:0][7:0]  tok_byte_ff;
   logic [2:0]       tok_esc_ff;
   logic [1:0]       tok_cnt_ff;
   logic [1:0]       tok_idx_ff;
   logic [2:0]       char_idx_ff;
   logic             last_ff;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_run_end_ff;
   logic             rsp_string_end_ff;

   logic             out_free;
   logic             emit;
   logic             at_tok_end;
   logic             at_plan_end;
   logic             load;
   logic [47:0]      word;
   logic [47:0]      word_sh;
   logic [7:0]       cur_char;

   // Current byte of the current token
   always_comb begin
      word        = exp_word(tok_byte_ff[tok_idx_ff], tok_esc_ff[tok_idx_ff]);
      word_sh     = word << {char_idx_ff, 3'b000};
      cur_char    = word_sh[47:40];
      at_tok_end  = (char_idx_ff ==
                     (exp_len(tok_byte_ff[tok_idx_ff], tok_esc_ff[tok_idx_ff]) - 3'd1));
      at_plan_end = at_tok_end && (tok_idx_ff == (tok_cnt_ff - 2'd1));
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = busy_ff && out_free;
   assign can_load = !busy_ff || (emit && at_plan_end);
   assign load     = plan_take && (plan.count != 2'd0);

   // Token sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (emit && at_plan_end) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_byte_ff <= plan.tok_byte;
         tok_esc_ff  <= plan.tok_esc;
         tok_cnt_ff  <= plan.count;
         last_ff     <= plan.last;
         tok_idx_ff  <= 2'd0;
         char_idx_ff <= 3'd0;
      end else if (emit) begin
         if (at_tok_end) begin
            tok_idx_ff  <= tok_idx_ff + 2'd1;
            char_idx_ff <= 3'd0;
         end else begin
            char_idx_ff <= char_idx_ff + 3'd1;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff       <= cur_char;
         rsp_run_end_ff    <= at_plan_end;
         rsp_string_end_ff <= at_plan_end && last_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_byte       = rsp_byte_ff;
   assign rsp_chan.out_run_end    = rsp_run_end_ff;
   assign rsp_chan.out_string_end = rsp_string_end_ff;

endmodule

/* sv/xml_text_escaper.sv */
// Streaming XML text escaper. Bytes of a string enter on req_chan, with in_last on the
// final byte, and escaped text leaves on rsp_chan one byte per item. & < > " ' become
// named entities, bytes below 32 become &#xNN; with uppercase hex, and a "&#x" starts a
// raw copy that runs up to the next ';' or the end of the string. A '&' is held back
// until the next two bytes show whether it opens a reference, so results for it come
// with a later item; in_last flushes everything, and zero-result items are possible.
// Rate: plain text, where each input item expands to one byte, flows at one byte per
// cycle while rsp_chan is ready; an item releasing entities occupies the one-byte result
// register for the total length of its expansions, and req_chan.ready stays low until its
// last byte is sent. An accepted byte passes through the input register and the emitter's
// token registers before it reaches the result register.
module xml_text_escaper (
   input  logic       clock,
   input  logic       reset,
   xte_req_if.sink    req_chan,
   xte_rsp_if.source  rsp_chan
);
   import xte_pkg::*;

   xte_plan_type plan;
   logic         plan_take;
   logic         can_load;

   xte_planner u_planner (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .can_load  (can_load),
      .plan_take (plan_take),
      .plan      (plan)
   );

   xte_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .plan_take (plan_take),
      .plan      (plan),
      .can_load  (can_load),
      .rsp_chan  (rsp_chan)
   );

endmodule
